// ===== rtl/assert_macros.svh =====
// assertion macros shared by the alpha map decoder rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AMD_ASSERT_HOLD(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");
`define AMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`else
`define AMD_ASSERT_HOLD(lbl, clk, rst_n, expr)
`define AMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/amd_pkg.sv =====
// shared types and constants of the alpha map decoder
// no dependencies; imported by every module of the block
package amd_pkg;

    localparam int unsigned MAP_SIDE_DEF = 64;
    localparam int unsigned CMD_DEPTH    = 4;
    localparam int unsigned RESULT_LIMIT = 64;
    localparam int unsigned NRES_W       = $clog2(RESULT_LIMIT);
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned IDX_W        = 12;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RLE    = 2'd0;
    localparam t_mode MODE_RAW    = 2'd1;
    localparam t_mode MODE_PACKED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MAP    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FILL,
        PH_LITERAL
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAIN,
        B_FLUSH,
        B_TAIL_RD,
        B_TAIL_EM
    } t_back_state;

    // one decoded byte worth of pixel work
    typedef struct packed {
        logic             restart;
        logic             is_fill;
        logic             dup_edge;
        logic             tail;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       v0;
        logic [7:0]       v1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [7:0]       alpha_first;
        logic [7:0]       alpha_second;
        logic [1:0]       count;
        logic             last;
        logic             complete;
    } t_result;

endpackage

// ===== rtl/amd_in_if.sv =====
// byte request channel of the alpha map decoder
// standalone valid/ready interface, no package needed
interface amd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, data_byte, restart, input ready);
    modport sink   (input valid, data_byte, restart, output ready);
endinterface

// ===== rtl/amd_out_if.sv =====
// pixel result channel of the alpha map decoder
// standalone valid/ready interface, no package needed
interface amd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_index;
    logic [7:0]  alpha_first;
    logic [7:0]  alpha_second;
    logic [1:0]  pixel_count;
    logic        last_of_item;
    logic        map_complete;

    modport source (output valid, pixel_index, alpha_first, alpha_second, pixel_count,
                    last_of_item, map_complete, input ready);
    modport sink   (input valid, pixel_index, alpha_first, alpha_second, pixel_count,
                    last_of_item, map_complete, output ready);
endinterface

// ===== rtl/alpha_map_decoder_unit.sv =====
// alpha map decoder top level: configuration registers, front end, command queue, back end
// depends on amd_pkg, amd_in_if, amd_out_if, amd_front, amd_cmd_fifo, amd_back
// Decodes a run-length, raw or packed 4-bit byte stream into a MAP_SIDE x MAP_SIDE map of
// 8-bit alpha values, reporting pixels as results of one or two consecutive pixels. Each
// byte that writes pixels becomes one command in a QUEUE_DEPTH-entry queue (four by
// default). Header bytes and bytes that write nothing are taken one per cycle, and the
// input stalls only while that queue is full. The back end takes a command from the
// queue and then emits its results in turn: a fill run of n pixels as ceil(n/2) results,
// and a literal or raw byte or a packed pair as one result. The last-row copy of a partial
// packed map then adds results read from the row store through a registered read. With
// an odd MAP_SIDE a pair that wraps a row puts both its columns in one bank, and the
// second write waits for a flush state. The output is registered; a result that waits for
// ready holds the back end, and the front end keeps taking bytes until the queue is full.
// The row store needs no clearing after reset.
`include "assert_macros.svh"
module alpha_map_decoder_unit import amd_pkg::*; #(
    parameter int unsigned MAP_SIDE    = MAP_SIDE_DEF,
    parameter int unsigned QUEUE_DEPTH = CMD_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    amd_in_if.sink                i_byte,
    amd_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mode    r_mode;
    logic     r_full_map;
    t_fifo_st fifo_st;
    t_cmd     push_cmd, head_cmd;
    logic     push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RLE;
            r_full_map <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DECODE_MODE: r_mode     <= i_cfg_data[1:0];
                REG_FULL_MAP:    r_full_map <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    amd_front #(
        .MAP_SIDE (MAP_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_mode     (r_mode),
        .i_full_map (r_full_map),
        .i_fifo_st  (fifo_st),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    amd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_st    (fifo_st)
    );

    amd_back #(
        .MAP_SIDE (MAP_SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_fifo_st (fifo_st),
        .o_pop     (pop),
        .o_pix     (o_pix)
    );

    // the final map pixel always closes the results of its byte
    `AMD_ASSERT_IMPLY(a_complete_is_last, i_clk, i_rst_n, o_pix.valid && o_pix.map_complete, o_pix.last_of_item)
    `AMD_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, o_pix.valid, o_pix.pixel_count == 2'd1 || o_pix.pixel_count == 2'd2)
    `AMD_ASSERT_IMPLY(a_single_zero, i_clk, i_rst_n, o_pix.valid && o_pix.pixel_count == 2'd1, o_pix.alpha_second == 8'h00)

endmodule

// ===== rtl/amd_front.sv =====
// front end: takes stream bytes, tracks position and run state, issues commands
// depends on amd_pkg and amd_in_if
module amd_front import amd_pkg::*; #(
    parameter int unsigned MAP_SIDE = MAP_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    amd_in_if.sink    i_byte,
    input  t_mode     i_mode,
    input  logic      i_full_map,
    input  t_fifo_st  i_fifo_st,
    output logic      o_push,
    output t_cmd      o_cmd
);

    localparam int unsigned TOTAL = MAP_SIDE * MAP_SIDE;
    localparam int unsigned POS_W = $clog2(TOTAL + 1);
    localparam int unsigned CW    = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam logic [POS_W-1:0] POS_TOTAL    = POS_W'(TOTAL);
    localparam logic [POS_W-1:0] POS_LAST_ROW = POS_W'((MAP_SIDE - 1) * MAP_SIDE);

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic             r_rst_pend, n_rst_pend;

    logic             accept;
    logic [POS_W-1:0] p, room, pk_n, pk_end;
    t_phase           ph;
    logic [CNT_W-1:0] rm, rm_dec;
    logic [CW-1:0]    fill_n;
    logic [3:0]       lo, hi;

    assign i_byte.ready = !i_fifo_st.full;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        p      = i_byte.restart ? '0 : r_pos;
        ph     = i_byte.restart ? PH_HEADER : r_phase;
        rm     = i_byte.restart ? '0 : r_rem;
        room   = POS_TOTAL - p;
        fill_n = (CW'(rm) > CW'(room)) ? CW'(room) : CW'(rm);
        pk_n   = (room >= POS_W'(2)) ? POS_W'(2) : POS_W'(1);
        pk_end = p + pk_n;
        rm_dec = (rm != '0) ? rm - CNT_W'(1) : '0;
        lo     = i_byte.data_byte[3:0];
        hi     = i_byte.data_byte[7:4];

        n_pos      = r_pos;
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_rst_pend = r_rst_pend;

        o_push          = 1'b0;
        o_cmd.restart   = i_byte.restart || r_rst_pend;
        o_cmd.is_fill   = 1'b0;
        o_cmd.dup_edge  = 1'b0;
        o_cmd.tail      = 1'b0;
        o_cmd.cnt       = CNT_W'(1);
        o_cmd.v0        = i_byte.data_byte;
        o_cmd.v1        = 8'h00;

        if (accept) begin
            n_pos   = p;
            n_phase = ph;
            n_rem   = rm;
            if (p < POS_TOTAL) begin
                unique case (i_mode)
                    MODE_RLE: begin
                        unique case (ph)
                            PH_FILL: begin
                                if (fill_n != '0) begin
                                    o_push        = 1'b1;
                                    o_cmd.is_fill = 1'b1;
                                    o_cmd.cnt     = CNT_W'(fill_n);
                                    n_pos         = p + POS_W'(fill_n);
                                end
                                n_phase = PH_HEADER;
                                n_rem   = '0;
                            end
                            PH_LITERAL: begin
                                o_push  = 1'b1;
                                n_pos   = p + POS_W'(1);
                                n_rem   = rm_dec;
                                n_phase = (rm_dec == '0) ? PH_HEADER : PH_LITERAL;
                            end
                            default: begin
                                n_rem = i_byte.data_byte[6:0];
                                if (i_byte.data_byte[7]) begin
                                    n_phase = PH_FILL;
                                end else if (i_byte.data_byte[6:0] != 7'd0) begin
                                    n_phase = PH_LITERAL;
                                end else begin
                                    n_phase = PH_HEADER;
                                end
                            end
                        endcase
                    end
                    MODE_PACKED: begin
                        // nibble times 17 is the nibble repeated
                        o_push         = 1'b1;
                        o_cmd.cnt      = CNT_W'(pk_n);
                        o_cmd.v0       = {lo, lo};
                        o_cmd.v1       = {hi, hi};
                        o_cmd.dup_edge = !i_full_map;
                        n_pos          = pk_end;
                        if (!i_full_map && pk_end >= POS_LAST_ROW && pk_end < POS_TOTAL) begin
                            o_cmd.tail = 1'b1;
                            n_pos      = POS_TOTAL;
                        end
                    end
                    default: begin
                        o_push = 1'b1;
                        n_pos  = p + POS_W'(1);
                    end
                endcase
            end
            // a restart that produced no command rides on the next one
            n_rst_pend = o_push ? 1'b0 : (i_byte.restart || r_rst_pend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_HEADER;
            r_rem      <= '0;
            r_rst_pend <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_rst_pend <= n_rst_pend;
        end
    end

endmodule

// ===== rtl/amd_cmd_fifo.sv =====
// short command queue between the front end and the pixel back end
// depends on amd_pkg
module amd_cmd_fifo import amd_pkg::*; #(
    parameter int unsigned DEPTH = CMD_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd     i_cmd,
    input  logic     i_pop,
    output t_cmd     o_cmd,
    output t_fifo_st o_st
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_st.full  = (r_count == CNT_FULL);
    assign o_st.empty = (r_count == '0);
    assign do_push    = i_push && !o_st.full;
    assign do_pop     = i_pop && !o_st.empty;
    assign o_cmd      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/amd_back.sv =====
// back end: expands commands into pixel pair results, keeps the per-column row store
// depends on amd_pkg and amd_out_if
module amd_back import amd_pkg::*; #(
    parameter int unsigned MAP_SIDE = MAP_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_fifo_st    i_fifo_st,
    output logic        o_pop,
    amd_out_if.source   o_pix
);

    localparam int unsigned TOTAL      = MAP_SIDE * MAP_SIDE;
    localparam int unsigned POS_W      = $clog2(TOTAL + 1);
    localparam int unsigned COL_W      = $clog2(MAP_SIDE);
    localparam int unsigned BANK_AW    = COL_W - 1;
    localparam int unsigned EVEN_DEPTH = (MAP_SIDE + 1) / 2;
    localparam int unsigned ODD_DEPTH  = MAP_SIDE / 2;
    localparam logic [POS_W-1:0]  POS_TOTAL = POS_W'(TOTAL);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAP_SIDE - 1);
    localparam logic [COL_W-1:0]  COL_EDGE  = COL_W'(MAP_SIDE - 2);
    localparam logic [NRES_W-1:0] NRES_LAST = NRES_W'(RESULT_LIMIT - 1);

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [COL_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_left, n_left;
    logic [NRES_W-1:0] r_nres, n_nres;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [BANK_AW-1:0] r_pend_addr, n_pend_addr;
    logic [7:0]       r_pend_data, n_pend_data;
    logic             r_pend_odd, n_pend_odd;

    // row store split by column parity so a pixel pair hits both banks at once, unless it wraps a row of odd side
    logic [7:0] r_even [EVEN_DEPTH];
    logic [7:0] r_odd  [ODD_DEPTH];
    logic [7:0] r_rd_even, r_rd_odd;

    logic               we_e, we_o, rd_en;
    logic [BANK_AW-1:0] wa_e, wa_o, ra_e, ra_o;
    logic [7:0]         wd_e, wd_o;

    logic             out_free;
    logic [POS_W-1:0] tail_left, pos_adv;
    logic [1:0]       k;
    logic [COL_W-1:0] col2, col3;
    logic [7:0]       va, vb;

    assign out_free = !r_out_valid || o_pix.ready;

    always_comb begin
        tail_left = POS_TOTAL - r_pos;
        if (r_state == B_TAIL_EM) begin
            k = (tail_left >= POS_W'(2)) ? 2'd2 : 2'd1;
        end else begin
            k = (r_left >= CNT_W'(2)) ? 2'd2 : 2'd1;
        end
        pos_adv = r_pos + POS_W'(k);
        col2    = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
        col3    = (col2 == COL_LAST) ? '0 : col2 + COL_W'(1);

        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_col       = r_col;
        n_left      = r_left;
        n_nres      = r_nres;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pix.ready;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        n_pend_odd  = r_pend_odd;

        o_pop = 1'b0;
        we_e  = 1'b0;
        we_o  = 1'b0;
        wa_e  = '0;
        wa_o  = '0;
        wd_e  = '0;
        wd_o  = '0;
        rd_en = 1'b0;
        ra_e  = r_col[0] ? col2[COL_W-1:1] : r_col[COL_W-1:1];
        ra_o  = r_col[0] ? r_col[COL_W-1:1] : col2[COL_W-1:1];
        va    = r_cmd.v0;
        vb    = 8'h00;

        unique case (r_state)
            B_IDLE: begin
                if (!i_fifo_st.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_left  = i_cmd.cnt;
                    n_nres  = '0;
                    n_state = B_MAIN;
                    if (i_cmd.restart) begin
                        n_pos = '0;
                        n_col = '0;
                    end
                end
            end
            B_MAIN: begin
                if (out_free) begin
                    va = r_cmd.v0;
                    if (r_cmd.is_fill || (r_cmd.dup_edge && r_col == COL_EDGE)) begin
                        vb = r_cmd.v0;
                    end else begin
                        vb = r_cmd.v1;
                    end
                    if (r_col[0]) begin
                        we_o = 1'b1;
                        wa_o = r_col[COL_W-1:1];
                        wd_o = va;
                    end else begin
                        we_e = 1'b1;
                        wa_e = r_col[COL_W-1:1];
                        wd_e = va;
                    end
                    n_left = r_left - CNT_W'(k);
                    if (k == 2'd2 && col2[0] != r_col[0]) begin
                        if (col2[0]) begin
                            we_o = 1'b1;
                            wa_o = col2[COL_W-1:1];
                            wd_o = vb;
                        end else begin
                            we_e = 1'b1;
                            wa_e = col2[COL_W-1:1];
                            wd_e = vb;
                        end
                    end
                    if (k == 2'd2 && col2[0] == r_col[0]) begin
                        // odd side, pair wraps a row: both columns in one bank
                        n_pend_addr = col2[COL_W-1:1];
                        n_pend_data = vb;
                        n_pend_odd  = col2[0];
                        n_state     = B_FLUSH;
                    end else if (n_left != '0) begin
                        n_state = B_MAIN;
                    end else if (r_cmd.tail) begin
                        n_state = B_TAIL_RD;
                    end else begin
                        n_state = B_IDLE;
                    end
                    n_out.idx          = IDX_W'(r_pos);
                    n_out.alpha_first  = va;
                    n_out.alpha_second = (k == 2'd2) ? vb : 8'h00;
                    n_out.count        = k;
                    n_out.last         = (n_left == '0) && !r_cmd.tail;
                    n_out.complete     = (pos_adv == POS_TOTAL);
                    n_out_valid        = 1'b1;
                    n_pos              = pos_adv;
                    n_col              = (k == 2'd2) ? col3 : col2;
                    n_nres             = r_nres + NRES_W'(1);
                end
            end
            B_FLUSH: begin
                if (r_pend_odd) begin
                    we_o = 1'b1;
                    wa_o = r_pend_addr;
                    wd_o = r_pend_data;
                end else begin
                    we_e = 1'b1;
                    wa_e = r_pend_addr;
                    wd_e = r_pend_data;
                end
                if (r_left != '0) begin
                    n_state = B_MAIN;
                end else if (r_cmd.tail) begin
                    n_state = B_TAIL_RD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_TAIL_RD: begin
                rd_en   = 1'b1;
                n_state = B_TAIL_EM;
            end
            B_TAIL_EM: begin
                if (out_free) begin
                    va = r_col[0] ? r_rd_odd : r_rd_even;
                    vb = r_col[0] ? r_rd_even : r_rd_odd;
                    n_out.idx          = IDX_W'(r_pos);
                    n_out.alpha_first  = va;
                    n_out.alpha_second = (k == 2'd2) ? vb : 8'h00;
                    n_out.count        = k;
                    n_out.last         = (pos_adv == POS_TOTAL) || (r_nres == NRES_LAST);
                    n_out.complete     = (pos_adv == POS_TOTAL);
                    n_out_valid        = 1'b1;
                    n_pos              = pos_adv;
                    n_col              = (k == 2'd2) ? col3 : col2;
                    n_nres             = r_nres + NRES_W'(1);
                    n_state            = n_out.last ? B_IDLE : B_TAIL_RD;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            r_even[wa_e] <= wd_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            r_odd[wa_o] <= wd_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_even <= r_even[ra_e];
            r_rd_odd  <= r_odd[ra_o];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_left      <= n_left;
        r_nres      <= n_nres;
        r_out       <= n_out;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
        r_pend_odd  <= n_pend_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pos       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_index  = r_out.idx;
    assign o_pix.alpha_first  = r_out.alpha_first;
    assign o_pix.alpha_second = r_out.alpha_second;
    assign o_pix.pixel_count  = r_out.count;
    assign o_pix.last_of_item = r_out.last;
    assign o_pix.map_complete = r_out.complete;

endmodule

// ===== sim/tb_alpha_map_decoder_unit.sv =====
// testbench for alpha_map_decoder_unit: directed and random byte streams in all decode modes
// depends on amd_pkg, amd_in_if, amd_out_if and the decoder rtl; predicts every pixel result
`timescale 1ns / 100ps
module tb_alpha_map_decoder_unit;
    import amd_pkg::*;

    localparam int SIDE         = MAP_SIDE_DEF;
    localparam int MAP_TOTAL    = SIDE * SIDE;
    localparam int ITEM_TARGET  = 370;
    localparam int DRAIN_CYCLES = 24;
    localparam int QUIET_LIMIT  = 4000;

    localparam t_mode MODE_ALIAS_RAW = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    amd_in_if  byte_ch ();
    amd_out_if pix_ch ();

    alpha_map_decoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_pix      (pix_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // decoder state as predicted
    t_mode       cur_mode;
    logic        cur_full;
    logic [12:0] map_pos;
    t_phase      run_st;
    logic [6:0]  run_left;
    logic [7:0]  col_last [SIDE];
    bit          pair_open;
    t_result     step_out [$];
    t_result     pending_pixels [$];

    int      fail_count;
    int      work_items;
    bit      no_idle;
    t_result got_px;
    t_result want_px;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pix_ch.ready <= no_idle || ($urandom_range(99) >= 29);
    end

    function automatic void note_fail(string msg);
        if (fail_count < 10)
            $display("%s", msg);
        fail_count++;
    endfunction

    function automatic void emit_pixel(logic [7:0] v);
        t_result r;
        if (map_pos >= MAP_TOTAL)
            return;
        col_last[map_pos % SIDE] = v;
        if (pair_open) begin
            r = step_out[step_out.size() - 1];
            r.alpha_second = v;
            r.count = 2'd2;
            if (map_pos == MAP_TOTAL - 1)
                r.complete = 1'b1;
            step_out[step_out.size() - 1] = r;
            pair_open = 0;
        end else if (step_out.size() < RESULT_LIMIT) begin
            r.idx          = map_pos[IDX_W-1:0];
            r.alpha_first  = v;
            r.alpha_second = 8'h00;
            r.count        = 2'd1;
            r.last         = 1'b0;
            r.complete     = (map_pos == MAP_TOTAL - 1);
            step_out.insert(step_out.size(), r);
            pair_open = 1;
        end
        map_pos = map_pos + 13'd1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic rs);
        logic [3:0] lo;
        logic [3:0] hi;
        t_result    r;
        int         k;
        step_out.delete();
        pair_open = 0;
        if (rs) begin
            map_pos  = '0;
            run_st   = PH_HEADER;
            run_left = '0;
        end
        if (map_pos >= MAP_TOTAL)
            return;
        if (cur_mode == MODE_RLE) begin
            case (run_st)
                PH_FILL: begin
                    for (k = 0; k < run_left; k++)
                        emit_pixel(b);
                    run_st   = PH_HEADER;
                    run_left = '0;
                end
                PH_LITERAL: begin
                    emit_pixel(b);
                    pair_open = 0;
                    if (run_left != 0)
                        run_left = run_left - 7'd1;
                    if (run_left == 0)
                        run_st = PH_HEADER;
                end
                default: begin
                    run_left = b[6:0];
                    if (b[7])
                        run_st = PH_FILL;
                    else if (run_left != 0)
                        run_st = PH_LITERAL;
                    else
                        run_st = PH_HEADER;
                end
            endcase
        end else if (cur_mode == MODE_PACKED) begin
            lo = b[3:0];
            hi = b[7:4];
            // partial map: second pixel of the pair at the next-to-last column repeats the first
            if (!cur_full && (map_pos % SIDE) == SIDE - 2)
                hi = lo;
            // {n,n} is n*17
            emit_pixel({lo, lo});
            emit_pixel({hi, hi});
            // partial map: last row is copied from the row above in the same step
            if (!cur_full && map_pos >= (SIDE - 1) * SIDE) begin
                while (map_pos < MAP_TOTAL)
                    emit_pixel(col_last[map_pos % SIDE]);
            end
        end else begin
            emit_pixel(b);
        end
        if (step_out.size() > 0) begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
        for (k = 0; k < step_out.size(); k++)
            pending_pixels.insert(pending_pixels.size(), step_out[k]);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
            got_px.idx          = pix_ch.pixel_index;
            got_px.alpha_first  = pix_ch.alpha_first;
            got_px.alpha_second = pix_ch.alpha_second;
            got_px.count        = pix_ch.pixel_count;
            got_px.last         = pix_ch.last_of_item;
            got_px.complete     = pix_ch.map_complete;
            if (pending_pixels.size() == 0) begin
                note_fail($sformatf("unexpected result idx %0d a %0h/%0h n %0d",
                    got_px.idx, got_px.alpha_first, got_px.alpha_second, got_px.count));
            end else begin
                want_px = pending_pixels.pop_front();
                if (got_px !== want_px)
                    note_fail($sformatf({"pixel mismatch exp idx %0d a %0h/%0h n %0d l %0b c %0b",
                        " | got idx %0d a %0h/%0h n %0d l %0b c %0b"},
                        want_px.idx, want_px.alpha_first, want_px.alpha_second,
                        want_px.count, want_px.last, want_px.complete,
                        got_px.idx, got_px.alpha_first, got_px.alpha_second,
                        got_px.count, got_px.last, got_px.complete));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        while (!no_idle && $urandom_range(99) < 29) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.restart   <= rs;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1)
            @(posedge i_clk);
        work_items++;
        decode_byte(b, rs);
    endtask

    // drop the request, let every expected result arrive, then let the pipeline settle
    task automatic wait_idle();
        int quiet;
        int last_size;
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        quiet = 0;
        while (pending_pixels.size() != 0 && quiet < QUIET_LIMIT) begin
            last_size = pending_pixels.size();
            @(posedge i_clk);
            if (pending_pixels.size() == last_size)
                quiet++;
            else
                quiet = 0;
        end
        if (pending_pixels.size() != 0) begin
            note_fail($sformatf("%0d results never arrived", pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DECODE_MODE)
            cur_mode = t_mode'(val);
        else if (idx == REG_FULL_MAP)
            cur_full = val[0];
        @(posedge i_clk);
    endtask

    // one run-length sequence, mostly well formed, with some noise and broken runs
    task automatic send_rle_run(input bit first);
        int pick;
        int cnt;
        int j;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom_range(255)), first || ($urandom_range(99) < 3));
        end else if (pick < 60) begin
            if ($urandom_range(3) == 0)
                cnt = $urandom_range(100, 127);
            else
                cnt = $urandom_range(20);
            send_byte({1'b1, 7'(cnt)}, first);
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 2);
        end else begin
            cnt = $urandom_range(6);
            send_byte({1'b0, 7'(cnt)}, first);
            for (j = 0; j < cnt; j++)
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 2);
        end
    endtask

    // restart and advance to the given position with fill runs
    task automatic prefill_to(input int target);
        int  gap;
        int  cnt;
        logic rs;
        set_reg(REG_DECODE_MODE, MODE_RLE);
        rs = 1'b1;
        do begin
            gap = rs ? target : target - map_pos;
            cnt = (gap > 127) ? $urandom_range(64, 127) : gap;
            send_byte({1'b1, 7'(cnt)}, rs);
            send_byte(8'($urandom_range(255)), 1'b0);
            rs = 1'b0;
        end while (map_pos < target);
    endtask

    task automatic test_rle_basics();
        send_byte(8'h83, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // literal header with no count
        send_byte(8'h00, 1'b0);
        // fill header with no count swallows its value byte
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7F, 1'b0);
        wait_idle();
    endtask

    task automatic test_raw_extremes();
        set_reg(REG_DECODE_MODE, MODE_RAW);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        set_reg(REG_DECODE_MODE, MODE_ALIAS_RAW);
        send_byte(8'h5A, 1'b0);
        wait_idle();
    endtask

    task automatic test_packed_nibbles();
        set_reg(REG_DECODE_MODE, MODE_PACKED);
        set_reg(REG_FULL_MAP, 2'd1);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    task automatic test_partial_edge_column();
        set_reg(REG_DECODE_MODE, MODE_RLE);
        // fill up to the next-to-last column
        send_byte({1'b1, 7'(SIDE - 2)}, 1'b1);
        send_byte(8'h3C, 1'b0);
        set_reg(REG_DECODE_MODE, MODE_PACKED);
        set_reg(REG_FULL_MAP, 2'd0);
        send_byte(8'h7C, 1'b0);
        send_byte(8'h21, 1'b0);
        wait_idle();
    endtask

    task automatic test_open_run_mode_switch();
        set_reg(REG_DECODE_MODE, MODE_RLE);
        send_byte(8'h85, 1'b0);
        set_reg(REG_DECODE_MODE, MODE_RAW);
        send_byte(8'h11, 1'b0);
        set_reg(REG_DECODE_MODE, MODE_RLE);
        send_byte(8'h22, 1'b0);
        wait_idle();
    endtask

    task automatic test_spare_registers();
        set_reg(REG_SPARE_A, 2'd3);
        set_reg(REG_SPARE_B, 2'd2);
        set_reg(REG_FULL_MAP, 2'd3);
    endtask

    task automatic test_random_mix();
        int   phase;
        int   kind;
        int   n;
        int   j;
        int   target;
        phase = 0;
        while (work_items < ITEM_TARGET) begin
            kind    = $urandom_range(3);
            no_idle = (phase == 2);
            case (kind)
                0: begin
                    set_reg(REG_DECODE_MODE, MODE_RLE);
                    set_reg(REG_FULL_MAP, CFG_DATA_W'($urandom_range(3)));
                    n = $urandom_range(8, 20);
                    for (j = 0; j < n; j++)
                        send_rle_run(j == 0);
                end
                1: begin
                    prefill_to($urandom_range(MAP_TOTAL - SIDE, MAP_TOTAL - 1));
                    set_reg(REG_DECODE_MODE, t_mode'($urandom_range(3)));
                    set_reg(REG_FULL_MAP, CFG_DATA_W'($urandom_range(3)));
                    n = $urandom_range(10, 30);
                    for (j = 0; j < n; j++) begin
                        if (cur_mode == MODE_RLE)
                            send_rle_run(1'b0);
                        else
                            send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
                    end
                end
                2: begin
                    // land near row 62 so the partial packed map copies its last row
                    target = (SIDE - 2) * SIDE + $urandom_range(2 * SIDE - 2);
                    if ($urandom_range(3) != 0)
                        target = target & ~1;
                    prefill_to(target);
                    set_reg(REG_DECODE_MODE, MODE_PACKED);
                    set_reg(REG_FULL_MAP, 2'd0);
                    n = $urandom_range(5, 40);
                    for (j = 0; j < n; j++)
                        send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
                end
                default: begin
                    set_reg(REG_DECODE_MODE, t_mode'($urandom_range(1, 3)));
                    set_reg(REG_FULL_MAP, CFG_DATA_W'($urandom_range(3)));
                    n = $urandom_range(20, 40);
                    send_byte(8'($urandom_range(255)), 1'b1);
                    for (j = 1; j < n; j++)
                        send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
                end
            endcase
            phase++;
        end
        no_idle = 0;
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.restart   = 1'b0;
        pix_ch.ready      = 1'b0;
        fail_count        = 0;
        work_items        = 0;
        no_idle           = 0;
        cur_mode          = MODE_RLE;
        cur_full          = 1'b1;
        map_pos           = '0;
        run_st            = PH_HEADER;
        run_left          = '0;
        foreach (col_last[k])
            col_last[k] = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rle_basics();
        test_raw_extremes();
        test_packed_nibbles();
        test_partial_edge_column();
        test_open_run_mode_switch();
        test_spare_registers();
        test_random_mix();
        wait_idle();

        if (fail_count == 0)
            $display("[alpha_map_decoder_unit] OK");
        else
            $display("[alpha_map_decoder_unit] ERROR");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("[alpha_map_decoder_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/amd_pkg.sv
rtl/amd_in_if.sv
rtl/amd_out_if.sv
rtl/amd_front.sv
rtl/amd_cmd_fifo.sv
rtl/amd_back.sv
rtl/alpha_map_decoder_unit.sv
sim/tb_alpha_map_decoder_unit.sv
